### rtl/cagc_pkg.sv
package cagc_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  // Magnitude estimator weights, unsigned Q0.16
  localparam int EST_ALPHA = 62098;
  localparam int EST_BETA  = 25722;
  localparam int MAG_FRAC  = 16;
  localparam int RATE_FRAC = 16;

  // Configuration register indexes
  localparam logic [1:0] REG_LOOP_RATE       = 2'd0;
  localparam logic [1:0] REG_REFERENCE_LEVEL = 2'd1;
  localparam logic [1:0] REG_GAIN_LIMIT      = 2'd2;
  localparam logic [1:0] REG_INITIAL_GAIN    = 2'd3;

  // Operand selects of the shared multiplier
  typedef logic [2:0] msel_t;
  localparam msel_t MSEL_RE    = 3'd0;
  localparam msel_t MSEL_IM    = 3'd1;
  localparam msel_t MSEL_ALPHA = 3'd2;
  localparam msel_t MSEL_BETA  = 3'd3;
  localparam msel_t MSEL_RATE  = 3'd4;

  // Step strobes from the sequencer to the datapath
  typedef struct packed {
    logic  ld_in;    // capture the input sample
    logic  mul_en;   // issue a product
    msel_t mul_sel;  // operands of that product
    logic  ld_ore;   // saturate the real product
    logic  ld_out;   // saturate the imaginary product, load the output register
    logic  ld_abs;   // form max and min of the magnitudes
    logic  ld_acc;   // hold the alpha product
    logic  ld_err;   // form the level error
    logic  ld_dlt;   // scale the gain step
    logic  ld_sum;   // add and saturate the gain
    logic  ld_gain;  // apply the limit, write the gain
  } ctrl_t;

endpackage

### rtl/cagc_mul.sv
module cagc_mul #(
  parameter int XW = 24,
  parameter int YW = 17
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [XW-1:0]      x,
  input  logic signed [YW-1:0]      y,
  output logic signed [XW+YW-1:0]   prod
);

  // Registered signed product; hold when not issued
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= x * y;
    end
  end

endmodule

### rtl/cagc_seq.sv
module cagc_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_busy,
  output logic            in_ready,
  output cagc_pkg::ctrl_t ctrl
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MRE  = 4'd1;
  localparam logic [3:0] ST_MIM  = 4'd2;
  localparam logic [3:0] ST_OUT  = 4'd3;
  localparam logic [3:0] ST_ABS  = 4'd4;
  localparam logic [3:0] ST_MAL  = 4'd5;
  localparam logic [3:0] ST_MBE  = 4'd6;
  localparam logic [3:0] ST_ERR  = 4'd7;
  localparam logic [3:0] ST_MRT  = 4'd8;
  localparam logic [3:0] ST_DLT  = 4'd9;
  localparam logic [3:0] ST_SUM  = 4'd10;
  localparam logic [3:0] ST_CAP  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MRE;
      ST_MRE:  state_next = ST_MIM;
      ST_MIM:  state_next = ST_OUT;
      ST_OUT:  if (!out_busy) state_next = ST_ABS;
      ST_ABS:  state_next = ST_MAL;
      ST_MAL:  state_next = ST_MBE;
      ST_MBE:  state_next = ST_ERR;
      ST_ERR:  state_next = ST_MRT;
      ST_MRT:  state_next = ST_DLT;
      ST_DLT:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_CAP;
      ST_CAP:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    ctrl         = '0;
    ctrl.mul_sel = cagc_pkg::MSEL_RE;
    unique case (state)
      ST_IDLE: ctrl.ld_in = in_valid;
      ST_MRE: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = cagc_pkg::MSEL_RE;
      end
      ST_MIM: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = cagc_pkg::MSEL_IM;
        ctrl.ld_ore  = 1'b1;
      end
      ST_OUT:  ctrl.ld_out = !out_busy;
      ST_ABS:  ctrl.ld_abs = 1'b1;
      ST_MAL: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = cagc_pkg::MSEL_ALPHA;
      end
      ST_MBE: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = cagc_pkg::MSEL_BETA;
        ctrl.ld_acc  = 1'b1;
      end
      ST_ERR:  ctrl.ld_err = 1'b1;
      ST_MRT: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = cagc_pkg::MSEL_RATE;
      end
      ST_DLT:  ctrl.ld_dlt = 1'b1;
      ST_SUM:  ctrl.ld_sum = 1'b1;
      ST_CAP:  ctrl.ld_gain = 1'b1;
      default: ctrl = '0;
    endcase
  end

endmodule

### rtl/complex_agc_loop_unit.sv
// Feedback AGC for complex samples. Each input transfer on the s_ side carries
// one I/Q sample; the block scales it by the current gain, rounds and
// saturates it, and returns it on the m_ side with a clip flag in m_tuser.
// The magnitude of that output (alpha*max + beta*min of |I|,|Q|) then steers
// the gain by loop_rate * (reference_level - magnitude), saturated to the
// gain range and capped at gain_limit when the limit is non-zero.
// One shared multiplier does all five products under a small sequencer, so a
// new sample is accepted only once the previous one, gain update included,
// is through; the result is loaded into the output register at the output
// step, after both sample products. s_tready is high only while the sequencer
// is idle.
// A stalled receiver holds the sequencer at the output step until the
// previous result is taken; the gain update then finishes as usual.
// Configuration writes (cfg_we/cfg_addr/cfg_data) take effect at once and
// belong to idle periods; writing initial_gain also reloads the gain.
// Synchronous reset empties the output register, returns the sequencer to
// idle and loads the register defaults, with the gain at 1.0.
module complex_agc_loop_unit #(
  parameter int SAMPLE_WIDTH   = cagc_pkg::SAMPLE_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = cagc_pkg::GAIN_FRAC_BITS_DEF,
  localparam int GW  = GAIN_FRAC_BITS + 8,
  localparam int TDW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [TDW-1:0] s_tdata,   // in_re, in_im, zero fill
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [TDW-1:0] m_tdata,   // out_re, out_im, zero fill
  output logic           m_tuser,   // clipped
  input  logic           cfg_we,
  input  logic [1:0]     cfg_addr,
  input  logic [GW-1:0]  cfg_data
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int GF   = GAIN_FRAC_BITS;
  localparam int EW   = ((SW > 16) ? SW : 16) + 2;      // level error width
  localparam int XW   = (GW > EW) ? GW : EW;            // multiplier x operand
  localparam int YW   = (SW > 17) ? SW : 17;            // multiplier y operand
  localparam int PW   = XW + YW;                        // product width
  localparam int SUMW = PW + 1;                         // gain sum width
  localparam int REFW = (SW - 1 > 16) ? SW - 1 : 16;    // reference register width
  localparam int DS   = cagc_pkg::RATE_FRAC + (SW - 1) - GF;

  localparam logic signed [PW-1:0]   HALF_G = PW'(1) << (GF - 1);
  localparam logic signed [PW-1:0]   HALF_M = PW'(1) << (cagc_pkg::MAG_FRAC - 1);
  localparam logic signed [PW-1:0]   SMAX   = (PW'(1) << (SW - 1)) - PW'(1);
  localparam logic signed [PW-1:0]   SMIN   = ~SMAX;
  localparam logic signed [SUMW-1:0] GMAX   = (SUMW'(1) << (GW - 1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] GMIN   = ~GMAX;
  localparam logic [REFW-1:0]        REF_RST  = REFW'(1) << (SW - 2);
  localparam logic signed [GW-1:0]   GAIN_ONE = GW'(1) << GF;
  localparam logic [15:0]            RATE_RST = 16'd66;

  // Configuration and gain state
  logic [15:0]          loop_rate;
  logic [REFW-1:0]      reference_level;
  logic [GW-2:0]        gain_limit;
  logic signed [GW-1:0] gain;

  // Sample path registers
  logic signed [SW-1:0] in_re, in_im;
  logic signed [SW-1:0] ore, oim;
  logic                 clip_re;
  logic [SW-1:0]        mx, mn;
  logic signed [PW-1:0] acc;
  logic signed [EW-1:0] err;
  logic signed [PW-1:0] delta;
  logic signed [GW-1:0] gsat;

  // Shared multiplier
  logic signed [XW-1:0] mul_x;
  logic signed [YW-1:0] mul_y;
  logic signed [PW-1:0] prod;

  cagc_pkg::ctrl_t ctrl;
  logic            out_busy;
  logic            in_xfer;

  assign out_busy = m_tvalid && !m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  cagc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_busy (out_busy),
    .in_ready (s_tready),
    .ctrl     (ctrl)
  );

  // Pick the operands of the product issued this cycle
  always_comb begin
    unique case (ctrl.mul_sel)
      cagc_pkg::MSEL_RE: begin
        mul_x = XW'(gain);
        mul_y = YW'(in_re);
      end
      cagc_pkg::MSEL_IM: begin
        mul_x = XW'(gain);
        mul_y = YW'(in_im);
      end
      cagc_pkg::MSEL_ALPHA: begin
        mul_x = XW'(mx);
        mul_y = YW'(cagc_pkg::EST_ALPHA);
      end
      cagc_pkg::MSEL_BETA: begin
        mul_x = XW'(mn);
        mul_y = YW'(cagc_pkg::EST_BETA);
      end
      cagc_pkg::MSEL_RATE: begin
        mul_x = XW'(err);
        mul_y = YW'(loop_rate);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  cagc_mul #(
    .XW (XW),
    .YW (YW)
  ) u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .x    (mul_x),
    .y    (mul_y),
    .prod (prod)
  );

  // Round half up to the sample grid and saturate
  logic signed [PW-1:0] rs;
  logic                 s_hi, s_lo;
  logic signed [SW-1:0] sat_s;

  always_comb begin
    rs    = (prod + HALF_G) >>> GF;
    s_hi  = rs > SMAX;
    s_lo  = rs < SMIN;
    sat_s = s_hi ? SMAX[SW-1:0] : (s_lo ? SMIN[SW-1:0] : rs[SW-1:0]);
  end

  // Magnitudes of the saturated output; -min reads as 2^(SW-1) unsigned
  logic [SW-1:0] are, aim;
  logic signed [SW-1:0] ore_n, oim_n;

  assign ore_n = -ore;
  assign oim_n = -oim;
  assign are   = ore[SW-1] ? ore_n : ore;
  assign aim   = oim[SW-1] ? oim_n : oim;

  // Magnitude estimate and level error; acc already carries the rounding half
  logic signed [PW-1:0] msum, msh;
  logic signed [EW-1:0] err_c;

  assign msum  = acc + prod;
  assign msh   = msum >>> cagc_pkg::MAG_FRAC;
  assign err_c = $signed({{(EW - REFW){1'b0}}, reference_level}) - EW'(msh);

  // Scale the rate product to the gain grid
  logic signed [PW-1:0] delta_c;

  if (DS > 0) begin : g_dn
    localparam logic signed [PW-1:0] HALF_D = PW'(1) << (DS - 1);
    assign delta_c = (prod + HALF_D) >>> DS;
  end else begin : g_up
    assign delta_c = prod <<< (-DS);
  end

  // Gain sum with saturation, then the limit
  logic signed [SUMW-1:0] gsum;
  logic signed [GW-1:0]   gsat_c;
  logic signed [GW-1:0]   limit_s;
  logic signed [GW-1:0]   gcap;

  assign gsum    = SUMW'(gain) + SUMW'(delta);
  assign gsat_c  = (gsum > GMAX) ? GMAX[GW-1:0] :
                   ((gsum < GMIN) ? GMIN[GW-1:0] : gsum[GW-1:0]);
  assign limit_s = $signed({1'b0, gain_limit});
  assign gcap    = ((gain_limit != '0) && (gsat > limit_s)) ? limit_s : gsat;

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      in_re <= s_tdata[SW-1:0];
      in_im <= s_tdata[2*SW-1:SW];
    end
    if (ctrl.ld_ore) begin
      ore     <= sat_s;
      clip_re <= s_hi || s_lo;
    end
    if (ctrl.ld_out) begin
      oim <= sat_s;
    end
    if (ctrl.ld_abs) begin
      mx <= (are > aim) ? are : aim;
      mn <= (are > aim) ? aim : are;
    end
    if (ctrl.ld_acc) begin
      acc <= prod + HALF_M;
    end
    if (ctrl.ld_err) begin
      err <= err_c;
    end
    if (ctrl.ld_dlt) begin
      delta <= delta_c;
    end
    if (ctrl.ld_sum) begin
      gsat <= gsat_c;
    end
  end

  // Output register: load on the output step, drop on the receiver's transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.ld_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      m_tdata <= TDW'({sat_s, ore});
      m_tuser <= clip_re || s_hi || s_lo;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_rate       <= RATE_RST;
      reference_level <= REF_RST;
      gain_limit      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cagc_pkg::REG_LOOP_RATE:       loop_rate       <= cfg_data[15:0];
        cagc_pkg::REG_REFERENCE_LEVEL: reference_level <= REFW'(cfg_data[15:0]);
        cagc_pkg::REG_GAIN_LIMIT:      gain_limit      <= cfg_data[GW-2:0];
        default:                       loop_rate       <= loop_rate;
      endcase
    end
  end

  // Gain: reload on an initial_gain write, else advance at the end of an item
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_ONE;
    end else if (cfg_we && (cfg_addr == cagc_pkg::REG_INITIAL_GAIN)) begin
      gain <= cfg_data;
    end else if (ctrl.ld_gain) begin
      gain <= gcap;
    end
  end

  // The output register is never overwritten while a result waits
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.ld_out |-> (!m_tvalid || m_tready))
    else $error("output register loaded while a result was pending");

  // An accepted item keeps the input side closed in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_tready)
    else $error("input accepted again while an item was in progress");

  // No multiplier work while idle
  a_idle_mul: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !ctrl.mul_en)
    else $error("multiplier issued while idle");

  // An updated gain respects a non-zero limit
  a_cap: assert property (@(posedge clk) disable iff (rst)
    (ctrl.ld_gain && !(cfg_we && (cfg_addr == cagc_pkg::REG_INITIAL_GAIN)))
    |=> (($past(gain_limit) == '0) || (gain <= $signed({1'b0, $past(gain_limit)}))))
    else $error("gain above the limit after an update");

endmodule

### test/complex_agc_loop_unit_tb.sv
module complex_agc_loop_unit_tb;

  localparam int SW  = cagc_pkg::SAMPLE_WIDTH_DEF;
  localparam int GFB = cagc_pkg::GAIN_FRAC_BITS_DEF;
  localparam int GW  = GFB + 8;
  localparam int TDW = ((2 * SW + 7) / 8) * 8;

  // The gain step lands in gain units: rate (Q0.16) times error (sample units)
  localparam int STEP_SHIFT = cagc_pkg::RATE_FRAC + (SW - 1) - GFB;

  localparam longint S_HI = (longint'(1) << (SW - 1)) - 1;
  localparam longint S_LO = -S_HI - 1;
  localparam longint G_HI = (longint'(1) << (GW - 1)) - 1;
  localparam longint G_LO = -G_HI - 1;

  // Cycles without any transfer before the run is declared hung. The longest
  // legitimate quiet stretch is the receiver hold-off below.
  localparam int WATCH_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  // Margin for the gain update, which runs on after the result is loaded
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic                 clip;
  } scaled_t;

  logic           clk;
  logic           rst;
  logic           s_tvalid;
  logic           s_tready;
  logic [TDW-1:0] s_tdata;   // in_re, in_im
  logic           m_tvalid;
  logic           m_tready;
  logic [TDW-1:0] m_tdata;   // out_re, out_im
  logic           m_tuser;   // clipped
  logic           cfg_we;
  logic [1:0]     cfg_addr;
  logic [GW-1:0]  cfg_data;

  // Shadow of the block: registers and the gain it carries between samples
  logic [15:0]          rate_st;
  logic [15:0]          level_st;
  logic [GW-2:0]        limit_st;
  logic signed [GW-1:0] gain_st;

  scaled_t scaled_q[$];   // scaled samples still to come out, oldest first

  int src_idle_pct;
  int snk_stall_pct;
  int rx_hold_req;
  int rx_hold_left;
  int quiet_cycles;
  int n_err;
  int n_sent;
  int n_checked;
  int n_clipped;
  int n_writes;

  complex_agc_loop_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Round half up: floor(v / 2^s + 1/2)
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                   inout bit hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Scale one sample by the current gain, then move the gain toward the
  // reference level by the alpha-max/beta-min magnitude of that output.
  function automatic scaled_t scale_and_adapt(input logic signed [SW-1:0] re,
                                              input logic signed [SW-1:0] im);
    longint  pr, pi, ar, ai, mx, mn, mag, err, step, g;
    bit      clip_hit, gain_hit;
    scaled_t r;
    clip_hit = 1'b0;
    gain_hit = 1'b0;
    pr = clamp(round_shift(longint'(re) * longint'(gain_st), GFB), S_LO, S_HI, clip_hit);
    pi = clamp(round_shift(longint'(im) * longint'(gain_st), GFB), S_LO, S_HI, clip_hit);
    ar = pr < 0 ? -pr : pr;
    ai = pi < 0 ? -pi : pi;
    mx = ar > ai ? ar : ai;
    mn = ar > ai ? ai : ar;
    mag = round_shift(longint'(cagc_pkg::EST_ALPHA) * mx +
                      longint'(cagc_pkg::EST_BETA) * mn, cagc_pkg::MAG_FRAC);
    err = longint'(level_st) - mag;
    step = round_shift(longint'(rate_st) * err, STEP_SHIFT);
    g = clamp(longint'(gain_st) + step, G_LO, G_HI, gain_hit);
    // The cap only pulls down; a negative gain is never raised by it
    if (limit_st != 0 && g > longint'(limit_st)) g = longint'(limit_st);
    gain_st = g[GW-1:0];
    r.re   = pr[SW-1:0];
    r.im   = pi[SW-1:0];
    r.clip = clip_hit;
    return r;
  endfunction

  task automatic note_miss(input string field, input longint want, input longint got);
    n_err++;
    if (n_err <= 10)
      $display("output %0d, %s: expected %0d, got %0d", n_checked, field, want, got);
  endtask

  // Compare one output transfer against the oldest expected sample
  task automatic check_scaled();
    scaled_t want;
    if (scaled_q.size() == 0) begin
      n_err++;
      if (n_err <= 10)
        $display("output transfer with nothing expected: re %0d im %0d clip %0b",
                 $signed(m_tdata[SW-1:0]), $signed(m_tdata[2*SW-1:SW]), m_tuser);
    end else begin
      want = scaled_q.pop_front();
      if ($signed(m_tdata[SW-1:0]) != want.re)
        note_miss("out_re", want.re, $signed(m_tdata[SW-1:0]));
      if ($signed(m_tdata[2*SW-1:SW]) != want.im)
        note_miss("out_im", want.im, $signed(m_tdata[2*SW-1:SW]));
      if (m_tuser != want.clip)
        note_miss("clipped", want.clip, m_tuser);
      if (want.clip) n_clipped++;
    end
    n_checked++;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_scaled();
      if (rx_hold_req != 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Watchdog: any transfer on either side resets the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("no transfer for %0d cycles, %0d samples still expected",
               quiet_cycles, scaled_q.size());
      $display("complex_agc_loop_unit_tb: errors");
      $finish;
    end
  end

  // Offer one sample; valid stays high after the transfer so back-to-back
  // calls keep the input busy. Every task returns just after a rising edge.
  task automatic send_sample(input logic signed [SW-1:0] re, input logic signed [SW-1:0] im);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDW'({im, re});
    do @(posedge clk); while (!s_tready);
    scaled_q.push_back(scale_and_adapt(re, im));
    n_sent++;
  endtask

  // Drop valid, drain every expected sample, let the gain update finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (scaled_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [GW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      cagc_pkg::REG_LOOP_RATE:       rate_st  = val[15:0];
      cagc_pkg::REG_REFERENCE_LEVEL: level_st = val[15:0];
      cagc_pkg::REG_GAIN_LIMIT:      limit_st = val[GW-2:0];
      cagc_pkg::REG_INITIAL_GAIN:    gain_st  = val;
      default: ;
    endcase
    n_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Register value for a random segment, extremes weighted in
  function automatic logic [GW-1:0] rand_reg(input logic [1:0] idx);
    int            pick;
    logic [GW-1:0] v;
    logic [GW-1:0] mag;
    pick = $urandom_range(7);
    v = GW'($urandom);
    case (idx)
      cagc_pkg::REG_LOOP_RATE, cagc_pkg::REG_REFERENCE_LEVEL: begin
        if (pick == 0) v = '0;
        else if (pick == 1) v = GW'(16'hFFFF);
        else if (pick < 6)
          v = GW'($urandom_range(1, (idx == cagc_pkg::REG_LOOP_RATE) ? 800 : 32767));
        else v = GW'(v[15:0]);
      end
      cagc_pkg::REG_GAIN_LIMIT: begin
        if (pick < 3) v = '0;
        else if (pick == 3) v = GW'(G_HI);
        else if (pick < 6) v = GW'($urandom_range(32768, 524288));
        else v = GW'(v[GW-2:0]);
      end
      cagc_pkg::REG_INITIAL_GAIN: begin
        mag = GW'($urandom_range(8192, 262144));
        if (pick == 0) v = GW'(G_LO);
        else if (pick == 1) v = GW'(G_HI);
        else if (pick < 5) v = mag;
        else if (pick == 5) v = -mag;
      end
      default: ;
    endcase
    return v;
  endfunction

  // One part of a random sample: mostly within the segment's amplitude,
  // sometimes full scale or a rail value
  function automatic logic [SW-1:0] rand_part(input int amp_bits);
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      case ($urandom_range(3))
        0: return SW'(S_LO);
        1: return SW'(S_HI);
        2: return '0;
        default: return '1;
      endcase
    end
    if (pick == 1) return SW'($urandom);
    return SW'($urandom_range(0, (1 << amp_bits) - 1) - (1 << (amp_bits - 1)));
  endfunction

  task automatic send_random(input int count, input int amp_bits);
    repeat (count) send_sample(rand_part(amp_bits), rand_part(amp_bits));
  endtask

  // From the reset gain of 1.0, adapting after each sample: zero, rails and odd values
  task automatic test_unity_gain();
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd1, -16'sd1);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sd12345, -16'sd23456);
    settle();
  endtask

  // Gain of -1.0: the most negative sample flips past the positive rail
  task automatic test_negative_gain();
    write_reg(cagc_pkg::REG_INITIAL_GAIN, 24'hFF0000);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(16'sd16384, -16'sd16384);
    settle();
  endtask

  // Drive the gain past both ends of its range; the next sample exposes it
  task automatic test_gain_overflow();
    write_reg(cagc_pkg::REG_LOOP_RATE, 24'h00FFFF);
    write_reg(cagc_pkg::REG_REFERENCE_LEVEL, 24'h00FFFF);
    write_reg(cagc_pkg::REG_INITIAL_GAIN, 24'h7F0000);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd1, -16'sd1);
    settle();
    write_reg(cagc_pkg::REG_REFERENCE_LEVEL, '0);
    write_reg(cagc_pkg::REG_INITIAL_GAIN, 24'h800000);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(16'sd1, 16'sd1);
    settle();
  endtask

  // Cap on a rising gain, cap leaving a negative gain alone, zero limit off
  task automatic test_gain_limit();
    write_reg(cagc_pkg::REG_REFERENCE_LEVEL, 24'h00FFFF);
    write_reg(cagc_pkg::REG_GAIN_LIMIT, GW'(70000));
    write_reg(cagc_pkg::REG_INITIAL_GAIN, 24'h010000);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd32767, 16'sd0);
    settle();
    write_reg(cagc_pkg::REG_REFERENCE_LEVEL, '0);
    write_reg(cagc_pkg::REG_INITIAL_GAIN, 24'hFF0000);
    send_sample(16'sd100, 16'sd100);
    send_sample(16'sd1000, 16'sd0);
    settle();
    write_reg(cagc_pkg::REG_REFERENCE_LEVEL, 24'h00FFFF);
    write_reg(cagc_pkg::REG_GAIN_LIMIT, '0);
    write_reg(cagc_pkg::REG_INITIAL_GAIN, 24'h7FFDA0);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd1, -16'sd1);
    settle();
  endtask

  // Bits above each register's width must be dropped
  task automatic test_wide_writes();
    write_reg(cagc_pkg::REG_LOOP_RATE, 24'hFF0042);
    write_reg(cagc_pkg::REG_REFERENCE_LEVEL, 24'hAB4000);
    write_reg(cagc_pkg::REG_GAIN_LIMIT, 24'h810000);
    write_reg(cagc_pkg::REG_INITIAL_GAIN, 24'h018000);
    send_sample(16'sd20000, -16'sd20000);
    send_sample(16'sd20000, 16'sd5);
    send_sample(-16'sd7, 16'sd3);
    settle();
  endtask

  // Random samples under a given idle mix, in segments with fresh settings;
  // each segment keeps one amplitude so the loop has room to converge
  task automatic test_random_phase(input int src_pct, input int snk_pct, input int count);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int seg = 0; seg < 4; seg++) begin
      write_reg(cagc_pkg::REG_LOOP_RATE, rand_reg(cagc_pkg::REG_LOOP_RATE));
      write_reg(cagc_pkg::REG_REFERENCE_LEVEL, rand_reg(cagc_pkg::REG_REFERENCE_LEVEL));
      write_reg(cagc_pkg::REG_GAIN_LIMIT, rand_reg(cagc_pkg::REG_GAIN_LIMIT));
      write_reg(cagc_pkg::REG_INITIAL_GAIN, rand_reg(cagc_pkg::REG_INITIAL_GAIN));
      send_random(count / 4, $urandom_range(2, SW));
      settle();
    end
  endtask

  // Hold the output off long enough that the input stalls, then let the
  // sender wait for a full drain before the next burst
  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_reg(cagc_pkg::REG_LOOP_RATE, 24'd66);
    write_reg(cagc_pkg::REG_REFERENCE_LEVEL, 24'd16384);
    write_reg(cagc_pkg::REG_GAIN_LIMIT, '0);
    write_reg(cagc_pkg::REG_INITIAL_GAIN, 24'h010000);
    rx_hold_req = HOLD_CYCLES;
    send_random(30, 12);
    s_tvalid <= 1'b0;
    while (scaled_q.size() != 0) @(posedge clk);
    send_random(30, SW);
    settle();
  endtask

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    cfg_we        = 1'b0;
    cfg_addr      = cagc_pkg::REG_LOOP_RATE;
    cfg_data      = '0;
    rate_st       = 16'd66;
    level_st      = 16'd16384;
    limit_st      = '0;
    gain_st       = GW'(1 << GFB);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    rx_hold_req   = 0;
    rx_hold_left  = 0;
    quiet_cycles  = 0;
    n_err         = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_clipped     = 0;
    n_writes      = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_unity_gain();
    test_negative_gain();
    test_gain_overflow();
    test_gain_limit();
    test_wide_writes();
    test_random_phase(0, 0, 280);
    test_random_phase(72, 0, 280);
    test_random_phase(0, 72, 280);
    test_random_phase(28, 28, 280);
    test_backpressure();

    // Anything still queued never came out
    if (scaled_q.size() != 0) begin
      n_err += scaled_q.size();
      $display("%0d expected samples never came out", scaled_q.size());
    end

    $display("%0d samples scaled and checked, %0d clipped, %0d register writes",
             n_checked, n_clipped, n_writes);
    $display("idle mixes: none, sender 72%%, receiver 72%%, both 28%%; one long output hold");
    if (n_err == 0) begin
      $display("complex_agc_loop_unit_tb: clean");
    end else begin
      $display("%0d mismatches", n_err);
      $display("complex_agc_loop_unit_tb: errors");
    end
    $finish;
  end

endmodule
